// ===== sv/snapcf_pkg.sv =====
// Shared types, register codes and helpers of the snapshot compare filter.
package snapcf_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 4096;
  localparam int unsigned CMD_QUEUE_DEPTH  = 4;
  localparam int unsigned RES_QUEUE_DEPTH  = 2;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 13;
  localparam int IDX_OUT_W = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd3;

  // Element size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Compare mode codes.
  localparam logic [1:0] MODE_EQUAL = 2'd0;
  localparam logic [1:0] MODE_RISE  = 2'd1;
  localparam logic [1:0] MODE_FALL  = 2'd2;

  localparam logic [1:0]       ELEMENT_BYTES_RST = SIZE_WORD;
  localparam logic [1:0]       COMPARE_MODE_RST  = MODE_EQUAL;
  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RST = 13'd4096;

  // Classification of one accepted item, handed from the front to the back.
  typedef struct packed {
    logic restore;
    logic first;
    logic last;
    logic failed;
  } cmd_ctrl_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] element_index;
    logic                 still_candidate;
    logic [CNT_W-1:0]     match_count;
    logic                 pass_done;
  } result_t;

  // Keeps the bytes that belong to an element; an unused size code acts as a word.
  function automatic logic [DATA_W-1:0] width_mask(logic [1:0] element_bytes);
    logic [DATA_W-1:0] mask;
    unique case (element_bytes)
      SIZE_BYTE: mask = 32'h0000_00FF;
      SIZE_HALF: mask = 32'h0000_FFFF;
      default:   mask = 32'hFFFF_FFFF;
    endcase
    return mask;
  endfunction

endpackage

// ===== sv/snapcf_fifo.sv =====
// Small register-based first-in first-out queue.
module snapcf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/snapcf_front.sv =====
// Front end: accepts items, tracks the pass position and classifies each item.
module snapcf_front #(
  parameter int unsigned IDX_W = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         operation_i,
  input  logic                         read_ok_i,
  input  logic [snapcf_pkg::CNT_W-1:0] eff_count_i,
  output snapcf_pkg::cmd_ctrl_t        cmd_ctrl_o,
  output logic [IDX_W-1:0]             cmd_index_o
);

  import snapcf_pkg::*;

  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  logic [IDX_W-1:0] pos_q, pos_d;
  logic             aborted_q, aborted_d;
  logic             first, last, failed;

  assign first  = (pos_q == '0);
  assign last   = ((CMP_W'(pos_q) + CMP_W'(1)) >= CMP_W'(eff_count_i));
  // A failed read poisons the rest of the pass; the pass start clears it.
  assign failed = (!first && aborted_q) || !read_ok_i;

  always_comb begin
    pos_d     = pos_q;
    aborted_d = aborted_q;
    if (accept_i) begin
      if (operation_i) begin
        pos_d     = '0;
        aborted_d = 1'b0;
      end else begin
        pos_d     = last ? '0 : pos_q + 1'b1;
        aborted_d = failed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      aborted_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      aborted_q <= aborted_d;
    end
  end

  assign cmd_ctrl_o.restore = operation_i;
  assign cmd_ctrl_o.first   = first;
  assign cmd_ctrl_o.last    = last;
  assign cmd_ctrl_o.failed  = failed;
  assign cmd_index_o        = pos_q;

endmodule

// ===== sv/snapcf_back.sv =====
// Back end: snapshot and candidate memories, compare, counting and result build.
module snapcf_back #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned IDX_W        = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    element_bytes_i,
  input  logic [1:0]                    compare_mode_i,
  input  logic [snapcf_pkg::DATA_W-1:0] target_value_i,
  input  logic [snapcf_pkg::CNT_W-1:0]  eff_count_i,
  input  logic                          cmd_valid_i,
  input  snapcf_pkg::cmd_ctrl_t         cmd_ctrl_i,
  input  logic [IDX_W-1:0]              cmd_index_i,
  input  logic [snapcf_pkg::DATA_W-1:0] cmd_sample_i,
  output logic                          cmd_pop_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output snapcf_pkg::result_t           res_o
);

  import snapcf_pkg::*;

  localparam int CAP = (MAX_ELEMENTS < ELEMENT_COUNT_RST) ? MAX_ELEMENTS : ELEMENT_COUNT_RST;
  localparam logic [CNT_W-1:0] PRIOR_RST = CNT_W'(CAP);

  logic [DATA_W-1:0] snap_mem [MAX_ELEMENTS];
  logic              mask_mem [MAX_ELEMENTS];

  logic              busy_q, busy_d;
  cmd_ctrl_t         ctrl_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0] snap_rd_q;
  logic              mask_rd_q;
  logic              snap_byp_q;
  logic [DATA_W-1:0] snap_byp_data_q;
  logic              mask_byp_q;
  logic              mask_byp_data_q;

  logic [IDX_W:0]    snap_fill_q, snap_fill_d;
  logic [IDX_W:0]    mask_fill_q, mask_fill_d;
  logic [CNT_W-1:0]  running_q, running_d;
  logic [CNT_W-1:0]  prior_q, prior_d;
  logic              skipped_q, skipped_d;

  logic              go, load;
  logic [DATA_W-1:0] wmask, now, prev_raw, prev;
  logic [IDX_W:0]    idx_ext;
  logic              skip, mbit, hit, cand;
  logic [CNT_W-1:0]  run_new;
  logic              snap_we, mask_we;

  assign go        = busy_q && !res_full_i;
  assign load      = cmd_valid_i && (!busy_q || go);
  assign cmd_pop_o = load;
  assign busy_d    = load ? 1'b1 : (go ? 1'b0 : busy_q);

  assign wmask   = width_mask(element_bytes_i);
  assign now     = sample_q & wmask;
  assign idx_ext = {1'b0, idx_q};
  assign skip    = ctrl_q.first ? (prior_q == '0) : skipped_q;

  // Entries beyond the fill marks were never written and read as their reset values.
  always_comb begin
    if (snap_byp_q) begin
      prev_raw = snap_byp_data_q;
    end else if (idx_ext < snap_fill_q) begin
      prev_raw = snap_rd_q;
    end else begin
      prev_raw = '0;
    end
    if (mask_byp_q) begin
      mbit = mask_byp_data_q;
    end else if (idx_ext < mask_fill_q) begin
      mbit = mask_rd_q;
    end else begin
      mbit = 1'b1;
    end
  end

  assign prev = prev_raw & wmask;

  always_comb begin
    unique case (compare_mode_i)
      MODE_EQUAL: hit = (now == target_value_i);
      MODE_RISE:  hit = (prev < now);
      MODE_FALL:  hit = (prev > now);
      default:    hit = 1'b0;
    endcase
  end

  assign cand    = !skip && !ctrl_q.failed && mbit && hit;
  assign run_new = (ctrl_q.first ? '0 : running_q) + CNT_W'(cand);
  assign snap_we = go && !ctrl_q.restore && !skip && !ctrl_q.failed;
  assign mask_we = go && !ctrl_q.restore;

  always_comb begin
    snap_fill_d = snap_fill_q;
    mask_fill_d = mask_fill_q;
    running_d   = running_q;
    prior_d     = prior_q;
    skipped_d   = skipped_q;
    if (go) begin
      if (ctrl_q.restore) begin
        mask_fill_d = '0;
        running_d   = '0;
        prior_d     = eff_count_i;
        skipped_d   = 1'b0;
      end else begin
        running_d = run_new;
        skipped_d = skip;
        if (ctrl_q.last) begin
          prior_d = run_new;
        end
        if (snap_we && (idx_ext >= snap_fill_q)) begin
          snap_fill_d = idx_ext + 1'b1;
        end
        if (idx_ext >= mask_fill_q) begin
          mask_fill_d = idx_ext + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      snap_fill_q <= '0;
      mask_fill_q <= '0;
      running_q   <= '0;
      prior_q     <= PRIOR_RST;
      skipped_q   <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      snap_fill_q <= snap_fill_d;
      mask_fill_q <= mask_fill_d;
      running_q   <= running_d;
      prior_q     <= prior_d;
      skipped_q   <= skipped_d;
    end
  end

  // Stage register and memory ports. A write leaving the stage in the same cycle
  // as a read of the same element is forwarded.
  always_ff @(posedge clk_i) begin
    if (snap_we) begin
      snap_mem[idx_q] <= now;
    end
    if (mask_we) begin
      mask_mem[idx_q] <= cand;
    end
    if (load) begin
      ctrl_q          <= cmd_ctrl_i;
      idx_q           <= cmd_index_i;
      sample_q        <= cmd_sample_i;
      snap_rd_q       <= snap_mem[cmd_index_i];
      mask_rd_q       <= mask_mem[cmd_index_i];
      snap_byp_q      <= snap_we && (idx_q == cmd_index_i);
      snap_byp_data_q <= now;
      mask_byp_q      <= mask_we && (idx_q == cmd_index_i);
      mask_byp_data_q <= cand;
    end
  end

  assign res_push_o = go;

  always_comb begin
    if (ctrl_q.restore) begin
      res_o.element_index   = '0;
      res_o.still_candidate = 1'b1;
      res_o.match_count     = eff_count_i;
      res_o.pass_done       = 1'b1;
    end else begin
      res_o.element_index   = IDX_OUT_W'(idx_q);
      res_o.still_candidate = cand;
      res_o.match_count     = run_new;
      res_o.pass_done       = ctrl_q.last;
    end
  end

endmodule

// ===== sv/snapshot_compare_filter_core.sv =====
// Top level of the snapshot compare filter: config registers, front, queues and back.
//
//   Channel   Direction  Handshake             Beat
//   items     in         push / full           operation, sample_value, read_ok
//   results   out        pop / empty           element_index, still_candidate,
//                                              match_count, pass_done
//   config    in         cfg_valid / cfg_ready register index and write data
//
// The block takes one item per cycle and returns one result per cycle while the
// result side does not stall; the limit is the single compare stage, which reads
// and writes the snapshot memory once each per item. Reset makes the whole snapshot
// read as zero and every element a candidate at once through fill marks, so there is
// no clearing pass. A stalled result side fills the two-entry result queue and then
// the command queue before full rises.
module snapshot_compare_filter_core #(
  parameter int unsigned MAX_ELEMENTS = snapcf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation_i,
  input  logic [snapcf_pkg::DATA_W-1:0]    sample_value_i,
  input  logic                             read_ok_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [snapcf_pkg::IDX_OUT_W-1:0] element_index_o,
  output logic                             still_candidate_o,
  output logic [snapcf_pkg::CNT_W-1:0]     match_count_o,
  output logic                             pass_done_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [snapcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [snapcf_pkg::DATA_W-1:0]    cfg_data_i
);

  import snapcf_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  // The count register is 13 bits wide, so no pass is ever longer than this.
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CAP     = (MAX_ELEMENTS < CNT_MAX) ? MAX_ELEMENTS : CNT_MAX;
  localparam int CMD_W   = $bits(cmd_ctrl_t) + IDX_W + DATA_W;
  localparam int RES_W   = $bits(result_t);

  // Configuration registers. Writes are always taken.
  logic [1:0]        element_bytes_q;
  logic [1:0]        compare_mode_q;
  logic [DATA_W-1:0] target_value_q;
  logic [CNT_W-1:0]  element_count_q;
  logic [CNT_W-1:0]  eff_count;
  logic              cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_bytes_q <= ELEMENT_BYTES_RST;
      compare_mode_q  <= COMPARE_MODE_RST;
      target_value_q  <= '0;
      element_count_q <= ELEMENT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_ELEMENT_BYTES: element_bytes_q <= cfg_data_i[1:0];
        CFG_COMPARE_MODE:  compare_mode_q  <= cfg_data_i[1:0];
        CFG_TARGET_VALUE:  target_value_q  <= cfg_data_i;
        CFG_ELEMENT_COUNT: element_count_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // A zero count acts as one element and a count above the memory depth saturates.
  always_comb begin
    if (element_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (element_count_q > CNT_W'(CAP)) begin
      eff_count = CNT_W'(CAP);
    end else begin
      eff_count = element_count_q;
    end
  end

  // Front end and the command queue that decouples it from the back end.
  logic             cmd_full, cmd_empty, cmd_pop, in_accept;
  cmd_ctrl_t        front_ctrl, back_ctrl;
  logic [IDX_W-1:0] front_index, back_index;
  logic [DATA_W-1:0] back_sample;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  snapcf_front #(
    .IDX_W (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .operation_i (operation_i),
    .read_ok_i   (read_ok_i),
    .eff_count_i (eff_count),
    .cmd_ctrl_o  (front_ctrl),
    .cmd_index_o (front_index)
  );

  assign cmd_wdata = {front_ctrl, front_index, sample_value_i};
  assign {back_ctrl, back_index, back_sample} = cmd_rdata;

  snapcf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  // Back end and the result queue that holds finished beats for the consumer.
  logic    res_full, res_push;
  result_t res_in, res_out;

  snapcf_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_bytes_i (element_bytes_q),
    .compare_mode_i  (compare_mode_q),
    .target_value_i  (target_value_q),
    .eff_count_i     (eff_count),
    .cmd_valid_i     (!cmd_empty),
    .cmd_ctrl_i      (back_ctrl),
    .cmd_index_i     (back_index),
    .cmd_sample_i    (back_sample),
    .cmd_pop_o       (cmd_pop),
    .res_full_i      (res_full),
    .res_push_o      (res_push),
    .res_o           (res_in)
  );

  logic [RES_W-1:0] res_rdata;

  snapcf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out           = result_t'(res_rdata);
  assign element_index_o   = res_out.element_index;
  assign still_candidate_o = res_out.still_candidate;
  assign match_count_o     = res_out.match_count;
  assign pass_done_o       = res_out.pass_done;

endmodule

// ===== test/testbench.sv =====
// Testbench for the snapshot compare filter core: directed table, random passes, predictor check.
`timescale 1ns / 1ps

module testbench;
  import snapcf_pkg::*;

  // Item operation codes.
  localparam bit OP_SAMPLE  = 1'b0;
  localparam bit OP_RESTORE = 1'b1;

  // Register values outside the defined codes.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] SIZE_UNUSED = 2'd3;

  localparam int unsigned ELEMENTS = MAX_ELEMENTS_DEF;

  typedef enum logic {ROW_CONFIG, ROW_ITEM} row_kind_e;

  // One row of the directed table: either a register write or an item beat.
  // A row with typed set carries its expected result; otherwise the
  // predictor supplies it.
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    data;
    bit                   op;
    bit                   ok;
    bit                   typed;
    result_t              want;
  } table_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic                 operation_i;
  logic [DATA_W-1:0]    sample_value_i;
  logic                 read_ok_i;
  logic                 empty;
  logic                 pop;
  logic [IDX_OUT_W-1:0] element_index_o;
  logic                 still_candidate_o;
  logic [CNT_W-1:0]     match_count_o;
  logic                 pass_done_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  snapshot_compare_filter_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .operation_i       (operation_i),
    .sample_value_i    (sample_value_i),
    .read_ok_i         (read_ok_i),
    .empty             (empty),
    .pop               (pop),
    .element_index_o   (element_index_o),
    .still_candidate_o (still_candidate_o),
    .match_count_o     (match_count_o),
    .pass_done_o       (pass_done_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [1:0]        size_code;
  logic [1:0]        mode_code;
  logic [DATA_W-1:0] target_word;
  logic [CNT_W-1:0]  count_reg;

  // Shadow copy of the filter state.
  logic [DATA_W-1:0] snap_mem [ELEMENTS];
  bit                cand_bits [ELEMENTS];
  int unsigned       scan_pos;
  int unsigned       pass_hits;
  int unsigned       last_total;
  bit                pass_failed;
  bit                pass_idle;

  // Results still owed by the block, oldest first.
  result_t    pending_results [$];
  table_row_t directed_rows [$];

  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  function automatic int unsigned pass_length();
    if (count_reg == 0) return 1;
    if (count_reg > ELEMENTS) return ELEMENTS;
    return int'(count_reg);
  endfunction

  function automatic logic [DATA_W-1:0] lane_mask();
    unique case (size_code)
      SIZE_BYTE: return 32'h0000_00FF;
      SIZE_HALF: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Narrows the candidate set by one item and returns the result it causes.
  function automatic void narrow_candidates(input bit op, input logic [DATA_W-1:0] value,
                                            input bit ok, output result_t res);
    int unsigned       len;
    int unsigned       p;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] prev;
    bit                hit;
    len = pass_length();
    if (op == OP_RESTORE) begin
      for (int i = 0; i < ELEMENTS; i++) cand_bits[i] = 1'b1;
      last_total  = len;
      scan_pos    = 0;
      pass_hits   = 0;
      pass_failed = 1'b0;
      pass_idle   = 1'b0;
      res.element_index   = '0;
      res.still_candidate = 1'b1;
      res.match_count     = len[CNT_W-1:0];
      res.pass_done       = 1'b1;
      return;
    end
    if (scan_pos >= ELEMENTS) scan_pos = 0;
    p = scan_pos;
    // The first element opens a pass; a pass with no candidates left is idle.
    if (p == 0) begin
      pass_hits   = 0;
      pass_failed = 1'b0;
      pass_idle   = (last_total == 0);
    end
    hit = 1'b0;
    if (!pass_idle) begin
      // A failed read poisons the rest of the pass and freezes the snapshot.
      if (!ok) pass_failed = 1'b1;
      if (!pass_failed) begin
        m    = lane_mask();
        now  = value & m;
        prev = snap_mem[p] & m;
        if (cand_bits[p]) begin
          unique case (mode_code)
            MODE_EQUAL: hit = (now == target_word);
            MODE_RISE:  hit = (prev < now);
            MODE_FALL:  hit = (prev > now);
            default:    hit = 1'b0;
          endcase
        end
        snap_mem[p] = now;
      end
    end
    cand_bits[p] = hit;
    pass_hits += hit;
    res.element_index   = p[IDX_OUT_W-1:0];
    res.still_candidate = hit;
    res.match_count     = pass_hits[CNT_W-1:0];
    // A count lowered mid-pass ends the pass at the next element.
    if (p + 1 >= len) begin
      res.pass_done = 1'b1;
      last_total    = pass_hits;
      scan_pos      = 0;
    end else begin
      res.pass_done = 1'b0;
      scan_pos      = p + 1;
    end
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    table_row_t row;
    row = '{kind: ROW_CONFIG, default: '0};
    row.kind    = ROW_CONFIG;
    row.reg_idx = idx;
    row.data    = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_item(bit op, logic [DATA_W-1:0] value, bit ok);
    table_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind = ROW_ITEM;
    row.op   = op;
    row.data = value;
    row.ok   = ok;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_check(bit op, logic [DATA_W-1:0] value, bit ok,
                                    int unsigned idx, bit cand, int unsigned cnt, bit done);
    table_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.data  = value;
    row.ok    = ok;
    row.typed = 1'b1;
    row.want.element_index   = idx[IDX_OUT_W-1:0];
    row.want.still_candidate = cand;
    row.want.match_count     = cnt[CNT_W-1:0];
    row.want.pass_done       = done;
    directed_rows.push_back(row);
  endfunction

  // Registers change only while nothing is in flight. Every item returns a
  // result, so an empty queue of owed results means the block is idle.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      CFG_ELEMENT_BYTES: size_code   = data[1:0];
      CFG_COMPARE_MODE:  mode_code   = data[1:0];
      CFG_TARGET_VALUE:  target_word = data;
      CFG_ELEMENT_COUNT: count_reg   = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one item beat, with a random gap in front of it, and records the
  // expected result once the beat is taken.
  task automatic send_item(bit op, logic [DATA_W-1:0] value, bit ok, bit typed,
                           result_t want);
    result_t predicted;
    if ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    push           <= 1'b1;
    operation_i    <= op;
    sample_value_i <= value;
    read_ok_i      <= ok;
    do @(posedge clk_i); while (full !== 1'b0);
    narrow_candidates(op, value, ok, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Result side: pop at random and check each popped beat against the
  // oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && pop && empty === 1'b0) begin
      got.element_index   = element_index_o;
      got.still_candidate = still_candidate_o;
      got.match_count     = match_count_o;
      got.pass_done       = pass_done_o;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: index %0d cand %0b count %0d done %0b",
                   got.element_index, got.still_candidate, got.match_count, got.pass_done);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.element_index !== want.element_index ||
            got.still_candidate !== want.still_candidate ||
            got.match_count !== want.match_count ||
            got.pass_done !== want.pass_done) begin
          if (mismatches < 10) begin
            $write("result mismatch: expected index %0d cand %0b count %0d done %0b,",
                   want.element_index, want.still_candidate, want.match_count,
                   want.pass_done);
            $display(" got index %0d cand %0b count %0d done %0b",
                     got.element_index, got.still_candidate, got.match_count,
                     got.pass_done);
          end
          mismatches++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    result_t           none;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] prev;
    logic [1:0]        pick_mode;
    logic [DATA_W-1:0] pick_target;
    logic [CNT_W-1:0]  pick_count;
    int unsigned       r;
    int unsigned       p;
    bit                ok;

    none           = '0;
    mismatches     = 0;
    send_gap_pct   = 21;
    recv_stall_pct = 85;

    size_code   = ELEMENT_BYTES_RST;
    mode_code   = COMPARE_MODE_RST;
    target_word = '0;
    count_reg   = ELEMENT_COUNT_RST;
    for (int i = 0; i < ELEMENTS; i++) begin
      snap_mem[i]  = '0;
      cand_bits[i] = 1'b1;
    end
    scan_pos    = 0;
    pass_hits   = 0;
    last_total  = pass_length();
    pass_failed = 1'b0;
    pass_idle   = 1'b0;

    rst_ni         <= 1'b0;
    push           <= 1'b0;
    pop            <= 1'b0;
    operation_i    <= OP_SAMPLE;
    sample_value_i <= '0;
    read_ok_i      <= 1'b1;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_ELEMENT_BYTES;
    cfg_data_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset leaves a zero snapshot, a zero target and a pass of
    // 4096 elements, so the first sample of zero matches.
    row_check(OP_SAMPLE, 32'h0, 1'b1, 0, 1'b1, 1, 1'b0);
    row_check(OP_RESTORE, 32'h0, 1'b1, 0, 1'b1, 4096, 1'b1);
    // A zero element count acts as a single element.
    row_cfg(CFG_ELEMENT_COUNT, 32'd0);
    row_check(OP_RESTORE, 32'h0, 1'b1, 0, 1'b1, 1, 1'b1);
    row_check(OP_SAMPLE, 32'h0, 1'b1, 0, 1'b1, 1, 1'b1);
    // A count above the region size saturates.
    row_cfg(CFG_ELEMENT_COUNT, 32'h1FFF);
    row_check(OP_RESTORE, 32'h0, 1'b1, 0, 1'b1, 4096, 1'b1);
    // Full-width equality, then a failed read that clears the rest of the pass.
    row_cfg(CFG_ELEMENT_COUNT, 32'd4);
    row_cfg(CFG_TARGET_VALUE, 32'hFFFF_FFFF);
    row_check(OP_RESTORE, 32'h0, 1'b1, 0, 1'b1, 4, 1'b1);
    row_check(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 0, 1'b1, 1, 1'b0);
    row_check(OP_SAMPLE, 32'h0, 1'b1, 1, 1'b0, 1, 1'b0);
    row_check(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 2, 1'b0, 1, 1'b0);
    row_check(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 3, 1'b0, 1, 1'b1);
    // Byte elements in rise mode; nothing rises, so the following pass is idle.
    row_cfg(CFG_COMPARE_MODE, DATA_W'(MODE_RISE));
    row_cfg(CFG_ELEMENT_BYTES, DATA_W'(SIZE_BYTE));
    row_item(OP_SAMPLE, 32'h0000_0100, 1'b1);
    row_item(OP_SAMPLE, 32'hABCD_0055, 1'b1);
    row_item(OP_SAMPLE, 32'h0000_0007, 1'b1);
    row_item(OP_SAMPLE, 32'h0000_0008, 1'b1);
    row_check(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 0, 1'b0, 0, 1'b0);
    row_check(OP_SAMPLE, 32'h0000_00FF, 1'b1, 1, 1'b0, 0, 1'b0);
    row_check(OP_SAMPLE, 32'h1234_5678, 1'b0, 2, 1'b0, 0, 1'b0);
    row_check(OP_SAMPLE, 32'h8000_0001, 1'b1, 3, 1'b0, 0, 1'b1);
    // A target wider than a half-word element can never be equal.
    row_cfg(CFG_COMPARE_MODE, DATA_W'(MODE_EQUAL));
    row_cfg(CFG_ELEMENT_BYTES, DATA_W'(SIZE_HALF));
    row_cfg(CFG_TARGET_VALUE, 32'h0001_0000);
    row_check(OP_RESTORE, 32'h0, 1'b1, 0, 1'b1, 4, 1'b1);
    row_check(OP_SAMPLE, 32'h0001_0000, 1'b1, 0, 1'b0, 0, 1'b0);
    // Fall mode, then the count is lowered below the position mid-pass.
    row_cfg(CFG_COMPARE_MODE, DATA_W'(MODE_FALL));
    row_item(OP_SAMPLE, 32'h0, 1'b1);
    row_cfg(CFG_ELEMENT_COUNT, 32'd2);
    row_item(OP_SAMPLE, 32'h5, 1'b1);
    // The unused compare mode never matches; the unused size acts as a word.
    row_cfg(CFG_COMPARE_MODE, DATA_W'(MODE_UNUSED));
    row_cfg(CFG_ELEMENT_BYTES, DATA_W'(SIZE_UNUSED));
    row_check(OP_SAMPLE, 32'h0, 1'b1, 0, 1'b0, 0, 1'b0);
    row_check(OP_SAMPLE, 32'hDEAD_BEEF, 1'b1, 1, 1'b0, 0, 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
      else
        send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].ok,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: twelve settings of fifty items, four under each idling
    // pattern. Most items are well-formed samples aimed at the current
    // element so that matches, rises and falls actually happen.
    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        send_gap_pct   = 85;
        recv_stall_pct = 21;
      end else if (seg == 8) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end

      r = $urandom_range(9);
      pick_mode = (r < 3) ? MODE_EQUAL : (r < 6) ? MODE_RISE : (r < 9) ? MODE_FALL : MODE_UNUSED;
      case ($urandom_range(3))
        0:       pick_target = $urandom;
        1:       pick_target = $urandom_range(255);
        2:       pick_target = $urandom_range(65535);
        default: pick_target = 32'hFFFF_FFFF;
      endcase
      r = $urandom_range(19);
      case (r)
        0:       pick_count = '0;
        1:       pick_count = 13'd4096;
        2:       pick_count = 13'h1FFF;
        3:       pick_count = CNT_W'($urandom_range(13, 4095));
        default: pick_count = CNT_W'($urandom_range(1, 12));
      endcase
      write_reg(CFG_ELEMENT_BYTES, $urandom_range(3));
      write_reg(CFG_COMPARE_MODE, DATA_W'(pick_mode));
      write_reg(CFG_TARGET_VALUE, pick_target);
      write_reg(CFG_ELEMENT_COUNT, DATA_W'(pick_count));

      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          send_item(OP_RESTORE, $urandom, 1'($urandom_range(1)), 1'b0, none);
        end else if (r < 14) begin
          send_item(OP_SAMPLE, $urandom, 1'($urandom_range(1)), 1'b0, none);
        end else begin
          p    = (scan_pos >= ELEMENTS) ? 0 : scan_pos;
          prev = snap_mem[p];
          m    = lane_mask();
          ok   = ($urandom_range(49) != 0);
          // Bits above the element size are junk and must be ignored.
          value = $urandom;
          if ($urandom_range(2) != 0) begin
            case (mode_code)
              MODE_EQUAL: value = (target_word & m) | (value & ~m);
              MODE_RISE:  value = ((prev + $urandom_range(1, 3)) & m) | (value & ~m);
              MODE_FALL:  value = ((prev - $urandom_range(1, 3)) & m) | (value & ~m);
              default: ;
            endcase
          end
          send_item(OP_SAMPLE, value, ok, 1'b0, none);
        end
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of some 650 beats.
  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
